// ===== rtl/core/pbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel bit encoder package
// Shared types, constants and the brightness scaling function.
// ----------------------------------------------------------------------------
package pbe_pkg;

    localparam int COLOR_W         = 8;
    localparam int WORDS_PER_PIXEL = 24;
    localparam int CNT_W           = $clog2(WORDS_PER_PIXEL);
    localparam int FIELD_W         = 16;
    localparam int IN_DATA_W       = 4 * COLOR_W;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(WORDS_PER_PIXEL - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_ONE  = 1'b0,
        CFG_DUTY_ZERO = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] bright;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] cnt;
    } t_ser_stat;

    // floor(c * b / 255), exact for every 8-bit c and b
    function automatic logic [COLOR_W-1:0] scale8(input logic [COLOR_W-1:0] c,
                                                  input logic [COLOR_W-1:0] b);
        logic [2*COLOR_W-1:0] p;
        logic [2*COLOR_W:0]   s;
        p = (2*COLOR_W)'(c) * (2*COLOR_W)'(b);
        s = {1'b0, p} + {{(COLOR_W+1){1'b0}}, p[2*COLOR_W-1:COLOR_W]} + 1'b1;
        return s[2*COLOR_W-1:COLOR_W];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/led_pixel_pwm_bit_encoder_unit.sv =====
// A pixel accepted into the input register reaches the output through the
// scaler register, the shift load and the output register.
// The bit serializer emits one duty word per cycle while the sink does not
// stall; the next pixel is taken while the current one is shifting.
// Reset (synchronous, active low) empties all stages and clears both duty
// registers to 0.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED pixel PWM bit encoder
// Scales a pixel by its brightness and emits 24 timer duty words, G-R-B,
// MSB first, with tlast on the final word.
// ----------------------------------------------------------------------------
module led_pixel_pwm_bit_encoder_unit #(
    parameter int DUTY_WIDTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // config write port
    input  wire                                 i_cfg_we,
    input  wire [pbe_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [pbe_pkg::FIELD_W-1:0]          i_cfg_wdata,
    // pixel in
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire [pbe_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,  // red, green, blue, pixel_brightness
    // duty words out
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    output logic [pbe_pkg::FIELD_W-1:0]         o_m_axis_tdata,  // duty
    output logic                                o_m_axis_tlast
);
    import pbe_pkg::*;

    logic [DUTY_WIDTH-1:0]    r_duty_one, r_duty_zero;
    logic                     r_in_valid, n_in_valid;
    t_pixel                   r_pix, n_pix;
    logic                     scl_ready, scl_valid, ser_ready;
    logic [3*COLOR_W-1:0]     scl_grb;
    t_ser_stat                ser_stat;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_one  <= '0;
            r_duty_zero <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DUTY_ONE:  r_duty_one  <= i_cfg_wdata[DUTY_WIDTH-1:0];
                CFG_DUTY_ZERO: r_duty_zero <= i_cfg_wdata[DUTY_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign o_s_axis_tready = !r_in_valid || scl_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        n_pix      = r_pix;
        if (o_s_axis_tready) begin
            n_in_valid = i_s_axis_tvalid;
            n_pix      = t_pixel'(i_s_axis_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        r_pix <= n_pix;
    end

    pbe_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_pix   (r_pix),
        .o_ready (scl_ready),
        .o_valid (scl_valid),
        .o_grb   (scl_grb),
        .i_ready (ser_ready)
    );

    pbe_ser #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (scl_valid),
        .i_grb       (scl_grb),
        .o_ready     (ser_ready),
        .i_duty_one  (r_duty_one),
        .i_duty_zero (r_duty_zero),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tlast     (o_m_axis_tlast),
        .o_stat      (ser_stat)
    );

`ifndef SYNTHESIS
    // idle serializer always sits at bit zero
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ser_stat.busy |-> (ser_stat.cnt == '0))
        else $error("serializer idle with nonzero bit count");

    // a word that closes a pixel is never followed directly by another last word
    a_no_double_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast)
        |=> !(o_m_axis_tvalid && o_m_axis_tlast))
        else $error("two consecutive last words");

    // a held pixel in the input register only stalls behind a full scaler
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && !scl_ready))
        else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/pbe_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel bit encoder - brightness scaler
// Scales the three colors by the pixel brightness and registers them in
// G-R-B order for the serializer.
// ----------------------------------------------------------------------------
module pbe_scale (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    input  pbe_pkg::t_pixel                     i_pix,
    output logic                                o_ready,
    output logic                                o_valid,
    output logic [3*pbe_pkg::COLOR_W-1:0]       o_grb,
    input  wire                                 i_ready
);
    import pbe_pkg::*;

    logic                     r_valid, n_valid;
    logic [3*COLOR_W-1:0]     r_grb, n_grb;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_grb   = r_grb;
        if (o_ready) begin
            n_valid = i_valid;
            n_grb   = {scale8(i_pix.green, i_pix.bright),
                       scale8(i_pix.red,   i_pix.bright),
                       scale8(i_pix.blue,  i_pix.bright)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_grb <= n_grb;
    end

    assign o_valid = r_valid;
    assign o_grb   = r_grb;

endmodule
`default_nettype wire

// ===== rtl/core/pbe_ser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel bit encoder - serializer
// Shifts the 24 scaled bits out MSB first into an output register, one duty
// word per cycle unless stalled. The next pixel loads as the last bit leaves.
// ----------------------------------------------------------------------------
module pbe_ser #(
    parameter int DUTY_WIDTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    input  wire [3*pbe_pkg::COLOR_W-1:0]        i_grb,
    output logic                                o_ready,
    input  wire [DUTY_WIDTH-1:0]                i_duty_one,
    input  wire [DUTY_WIDTH-1:0]                i_duty_zero,
    output logic                                o_tvalid,
    input  wire                                 i_tready,
    output logic [pbe_pkg::FIELD_W-1:0]         o_tdata,
    output logic                                o_tlast,
    output pbe_pkg::t_ser_stat                  o_stat
);
    import pbe_pkg::*;

    logic                     r_busy, n_busy;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [3*COLOR_W-1:0]     r_shift, n_shift;
    logic                     r_ovalid, n_ovalid;
    logic [FIELD_W-1:0]       r_duty, n_duty;
    logic                     r_last, n_last;
    logic                     out_free, step, at_last;

    assign out_free = !r_ovalid || i_tready;
    assign step     = out_free && r_busy;
    assign at_last  = (r_cnt == LAST_WORD);
    assign o_ready  = !r_busy || (step && at_last);

    always_comb begin
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_ovalid = r_ovalid;
        n_duty   = r_duty;
        n_last   = r_last;
        if (step) begin
            n_ovalid = 1'b1;
            n_duty   = r_shift[3*COLOR_W-1] ? FIELD_W'(i_duty_one) : FIELD_W'(i_duty_zero);
            n_last   = at_last;
            n_shift  = {r_shift[3*COLOR_W-2:0], 1'b0};
            if (at_last) begin
                n_busy = 1'b0;
                n_cnt  = '0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end else if (out_free) begin
            n_ovalid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_shift = i_grb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_shift <= n_shift;
        r_duty  <= n_duty;
        r_last  <= n_last;
    end

    assign o_tvalid    = r_ovalid;
    assign o_tdata     = r_duty;
    assign o_tlast     = r_last;
    assign o_stat.busy = r_busy;
    assign o_stat.cnt  = r_cnt;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pixel PWM bit encoder testbench
// Sends pixels through the stream input and scores every duty word against an
// in-bench encoder: brightness scaling, G-R-B bit order, MSB first, tlast on
// word 24. It covers the duty registers at reset, at their extremes and at
// random values, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

    import pbe_pkg::*;

    localparam int          DUTY_W     = 16;
    localparam int          LAT_CYCLES = 8;
    localparam int          RAND_ITEMS = 132;
    localparam int unsigned RUN_LIMIT  = 200000;
    localparam logic [FIELD_W-1:0] DUTY_MASK = FIELD_W'((32'd1 << DUTY_W) - 1);

    typedef struct packed {
        logic [FIELD_W-1:0] duty;
        logic               last_bit;
    } t_duty_word;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  bright;
        bit          typed;
        logic [23:0] grb;   // scaled green, red, blue, typed rows only
    } t_pixel_row;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_we    = 1'b0;
    t_cfg_idx             cfg_idx   = CFG_DUTY_ONE;
    logic [FIELD_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    t_pixel               s_pixel   = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [FIELD_W-1:0]   m_tdata;
    logic                 m_tlast;

    logic [FIELD_W-1:0]   duty_one_val  = '0;
    logic [FIELD_W-1:0]   duty_zero_val = '0;
    t_duty_word           pending_duty_q[$];
    int                   mismatch_cnt  = 0;
    int                   src_gap_pct   = 28;
    int                   rx_stall_pct  = 51;
    int unsigned          cycle_cnt     = 0;

    // red, green, blue, brightness, typed, expected scaled G-R-B
    t_pixel_row dir_rows[15] = '{
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'hFFFFFF},  // duty regs still at reset
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'hFFFFFF},
        '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 24'h000000},
        '{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 24'h000000},  // zero brightness
        '{8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1, 24'h00FFFF},
        '{8'hAA, 8'h55, 8'h0F, 8'hFF, 1'b1, 24'h55AA0F},
        '{8'h80, 8'h01, 8'h7F, 8'hFF, 1'b1, 24'h01807F},
        '{8'h12, 8'h34, 8'h56, 8'h00, 1'b1, 24'h000000},
        '{8'h01, 8'h01, 8'h01, 8'hFF, 1'b1, 24'h010101},
        '{8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 24'hFF0000},
        '{8'hFF, 8'hFE, 8'h80, 8'h01, 1'b0, 24'h000000},
        '{8'hFF, 8'hFF, 8'hFF, 8'h80, 1'b0, 24'h000000},
        '{8'hFF, 8'h01, 8'h80, 8'hFE, 1'b0, 24'h000000},
        '{8'h5A, 8'hC3, 8'h3C, 8'h7F, 1'b0, 24'h000000},
        '{8'h9D, 8'h62, 8'hE7, 8'hAB, 1'b0, 24'h000000}
    };

    led_pixel_pwm_bit_encoder_unit #(
        .DUTY_WIDTH (DUTY_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_pixel),  // red, green, blue, pixel_brightness
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),  // duty
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [7:0] scale_level(logic [7:0] c, logic [7:0] b);
        int unsigned prod;
        prod = int'(c) * int'(b);
        return 8'(prod / 255);
    endfunction

    // one duty word per bit of G-R-B, MSB first
    function automatic void push_duty_words(logic [23:0] grb);
        t_duty_word w;
        for (int k = 0; k < WORDS_PER_PIXEL; k++) begin
            w.duty     = (grb[23-k] ? duty_one_val : duty_zero_val) & DUTY_MASK;
            w.last_bit = (k == WORDS_PER_PIXEL - 1);
            pending_duty_q.push_back(w);
        end
    endfunction

    function automatic void encode_pixel(t_pixel px);
        push_duty_words({scale_level(px.green, px.bright),
                         scale_level(px.red,   px.bright),
                         scale_level(px.blue,  px.bright)});
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(1, 3));
            3:       return 8'($urandom_range(252, 254));
            4:       return 8'($urandom_range(126, 129));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(t_pixel_row row);
        t_pixel px;
        px = '{bright: row.bright, blue: row.blue, green: row.green, red: row.red};
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_pixel  <= px;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (row.typed) begin
            push_duty_words(row.grb);
        end else begin
            encode_pixel(px);
        end
    endtask

    task automatic wait_drained();
        while (pending_duty_q.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES) @(posedge i_clk);
    endtask

    // both registers back to back, we stays high across the pair
    task automatic set_duty(logic [FIELD_W-1:0] one_val, logic [FIELD_W-1:0] zero_val);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_DUTY_ONE;
        cfg_wdata <= one_val;
        @(posedge i_clk);
        duty_one_val = one_val;
        cfg_idx   <= CFG_DUTY_ZERO;
        cfg_wdata <= zero_val;
        @(posedge i_clk);
        duty_zero_val = zero_val;
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random(int gap_pct, int stall_pct,
                              logic [FIELD_W-1:0] one_val, logic [FIELD_W-1:0] zero_val);
        t_pixel_row row;
        src_gap_pct  = gap_pct;
        rx_stall_pct = stall_pct;
        set_duty(one_val, zero_val);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            row.red    = rand_level();
            row.green  = rand_level();
            row.blue   = rand_level();
            row.bright = rand_level();
            row.typed  = 1'b0;
            row.grb    = '0;
            send_pixel(row);
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // sink side: score accepted words, then pick next tready
    always @(posedge i_clk) begin : rx_score
        t_duty_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_duty_q.size() == 0) begin
                $error("unexpected word: duty %0h, last_bit %0b", m_tdata, m_tlast);
                mismatch_cnt++;
            end else begin
                want = pending_duty_q.pop_front();
                if (m_tdata !== want.duty) begin
                    $error("duty: expected %0h, actual %0h", want.duty, m_tdata);
                    mismatch_cnt++;
                end
                if (m_tlast !== want.last_bit) begin
                    $error("last_bit: expected %0b, actual %0b", want.last_bit, m_tlast);
                    mismatch_cnt++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first pixel sees both duty registers at their reset value
        send_pixel(dir_rows[0]);
        s_tvalid <= 1'b0;
        wait_drained();

        set_duty(16'hFFFF, 16'h0000);
        for (int i = 1; i < $size(dir_rows); i++) begin
            send_pixel(dir_rows[i]);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        run_random(28, 51, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_random(51, 28, 16'h0000, 16'hFFFF);
        run_random(0, 0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));

        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
